[design/phc_pkg.sv]
// Shared types and constants for the proximity hysteresis counter.
package phc_pkg;

  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 1;
  localparam int TOTAL_BITS   = 20;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HELLO = 1'b0,
    CFG_RESET = 1'b1
  } cfg_idx_t;

  // Products formed by the shared multiplier, in issue order.
  typedef enum logic [3:0] {
    OP_H2,
    OP_R2,
    OP_RX2,
    OP_RY2,
    OP_KX2,
    OP_KY2,
    OP_PX2,
    OP_PY2,
    OP_PXKX,
    OP_PYKY,
    OP_H2DN,
    OP_S1DN,
    OP_UP2
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mul_en;
    op_t  op;
    logic decide;
  } phc_cmd_t;

endpackage

[design/phc_ctrl.sv]
// Sequencer for the proximity hysteresis counter: handshakes and product schedule.
module phc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output phc_pkg::phc_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_WB,
    S_DECIDE
  } state_t;

  state_t         state_r, state_nxt;
  phc_pkg::op_t   op_r, op_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           load;
  logic           slot_free;
  logic           decide;

  assign in_stall  = (state_r != S_IDLE);
  assign load      = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign decide    = (state_r == S_DECIDE) && slot_free;
  assign out_valid = out_valid_r;

  assign cmd.load   = load;
  assign cmd.mul_en = (state_r == S_MUL);
  assign cmd.op     = op_r;
  assign cmd.decide = decide;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_MUL;
          op_nxt    = phc_pkg::OP_H2;
        end
      end
      S_MUL: begin
        if (op_r == phc_pkg::OP_UP2) begin
          state_nxt = S_WB;
        end else begin
          op_nxt = phc_pkg::op_t'(op_r + 4'd1);
        end
      end
      S_WB: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (decide) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= phc_pkg::OP_H2;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A finished result never overwrites one still waiting.
  a_decide_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> slot_free)
    else $error("result written while previous result pending");

  // Every request starts the schedule at its first product.
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == S_MUL) && (op_r == phc_pkg::OP_H2))
    else $error("schedule did not start at first product");

  // A result only appears after a decision.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(decide))
    else $error("result valid without decision");

  // The last product is written back before the decision.
  a_wb_then_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) && (op_r == phc_pkg::OP_UP2) |=> (state_r == S_WB) ##1
      (state_r == S_DECIDE))
    else $error("decision not preceded by writeback");

endmodule

[design/phc_dp.sv]
// Datapath for the proximity hysteresis counter: shared multiplier, sums, tracker state.
module phc_dp #(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  phc_pkg::phc_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic [phc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [phc_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  logic signed [COORD_BITS-1:0]        in_first_x,
  input  logic signed [COORD_BITS-1:0]        in_first_y,
  input  logic signed [COORD_BITS-1:0]        in_second_x,
  input  logic signed [COORD_BITS-1:0]        in_second_y,
  input  logic                                in_restart,
  output logic                                out_event_now,
  output logic [phc_pkg::TOTAL_BITS-1:0]      out_event_total,
  output logic                                out_is_armed
);

  localparam int RW  = COORD_BITS + 1;           // separation
  localparam int KW  = COORD_BITS + 2;           // change of separation
  localparam int AW  = 2 * COORD_BITS + 4;       // sums of products
  localparam int SQW = 2 * phc_pkg::CFG_BITS;    // squared radius
  localparam int OW  = (AW > SQW + 1) ? AW : SQW + 1;
  localparam int PW  = 2 * OW;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Sample load
  logic signed [RW-1:0] rx_d, ry_d;
  logic signed [KW-1:0] kx_d, ky_d;
  logic signed [RW-1:0] rx_r, ry_r, prev_rx_r, prev_ry_r;
  logic signed [KW-1:0] kx_r, ky_r;
  logic                 restart_r;

  // Configuration and squared radii
  logic [phc_pkg::CFG_BITS-1:0] hello_r, reset_r;
  logic [SQW-1:0]               h2_r, r2_r;

  // Multiplier and accumulators
  logic signed [OW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_r;
  logic                 wb_en_r;
  phc_pkg::op_t         wb_op_r;
  logic signed [AW-1:0] s1_r, s2_r, up_r, dn_r, prod_lo;
  logic signed [PW-1:0] t_r, hd_r;

  // Tracker state
  logic                  have_prev_r, armed_r, ev_r;
  logic [COUNT_BITS-1:0] cnt_r;

  // Decision
  logic                  first, knz, interior, fire, armed_n;
  logic                  le_h2, gt_r2, s1_le_s2, t_le_hd;
  logic signed [AW:0]    up_dn;
  logic [COUNT_BITS-1:0] cnt_base, cnt_n;

  assign rx_d = RW'(in_first_x) - RW'(in_second_x);
  assign ry_d = RW'(in_first_y) - RW'(in_second_y);
  assign kx_d = KW'(rx_d) - KW'(prev_rx_r);
  assign ky_d = KW'(ry_d) - KW'(prev_ry_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_r      <= rx_d;
      ry_r      <= ry_d;
      kx_r      <= kx_d;
      ky_r      <= ky_d;
      restart_r <= in_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hello_r <= '0;
      reset_r <= '0;
    end else if (cfg_we) begin
      case (phc_pkg::cfg_idx_t'(cfg_index))
        phc_pkg::CFG_HELLO: hello_r <= cfg_wdata;
        phc_pkg::CFG_RESET: reset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      phc_pkg::OP_H2: begin
        op_a = OW'($signed({1'b0, hello_r}));
        op_b = OW'($signed({1'b0, hello_r}));
      end
      phc_pkg::OP_R2: begin
        op_a = OW'($signed({1'b0, reset_r}));
        op_b = OW'($signed({1'b0, reset_r}));
      end
      phc_pkg::OP_RX2: begin
        op_a = OW'(rx_r);
        op_b = OW'(rx_r);
      end
      phc_pkg::OP_RY2: begin
        op_a = OW'(ry_r);
        op_b = OW'(ry_r);
      end
      phc_pkg::OP_KX2: begin
        op_a = OW'(kx_r);
        op_b = OW'(kx_r);
      end
      phc_pkg::OP_KY2: begin
        op_a = OW'(ky_r);
        op_b = OW'(ky_r);
      end
      phc_pkg::OP_PX2: begin
        op_a = OW'(prev_rx_r);
        op_b = OW'(prev_rx_r);
      end
      phc_pkg::OP_PY2: begin
        op_a = OW'(prev_ry_r);
        op_b = OW'(prev_ry_r);
      end
      phc_pkg::OP_PXKX: begin
        op_a = OW'(prev_rx_r);
        op_b = OW'(kx_r);
      end
      phc_pkg::OP_PYKY: begin
        op_a = OW'(prev_ry_r);
        op_b = OW'(ky_r);
      end
      phc_pkg::OP_H2DN: begin
        op_a = OW'($signed({1'b0, h2_r}));
        op_b = OW'(dn_r);
      end
      phc_pkg::OP_S1DN: begin
        op_a = OW'(s1_r);
        op_b = OW'(dn_r);
      end
      phc_pkg::OP_UP2: begin
        op_a = OW'(up_r);
        op_b = OW'(up_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_en_r <= 1'b0;
    end else begin
      wb_en_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= op_a * op_b;
    wb_op_r <= cmd.op;
  end

  assign prod_lo = $signed(prod_r[AW-1:0]);

  // Writeback in the cycle after the multiply
  always_ff @(posedge clk) begin
    if (wb_en_r) begin
      case (wb_op_r)
        phc_pkg::OP_H2:   h2_r <= prod_r[SQW-1:0];
        phc_pkg::OP_R2:   r2_r <= prod_r[SQW-1:0];
        phc_pkg::OP_RX2:  s2_r <= prod_lo;
        phc_pkg::OP_RY2:  s2_r <= s2_r + prod_lo;
        phc_pkg::OP_KX2:  dn_r <= prod_lo;
        phc_pkg::OP_KY2:  dn_r <= dn_r + prod_lo;
        phc_pkg::OP_PX2:  s1_r <= prod_lo;
        phc_pkg::OP_PY2:  s1_r <= s1_r + prod_lo;
        phc_pkg::OP_PXKX: up_r <= prod_lo;
        phc_pkg::OP_PYKY: up_r <= up_r + prod_lo;
        phc_pkg::OP_H2DN: hd_r <= prod_r;
        phc_pkg::OP_S1DN: t_r  <= prod_r;
        phc_pkg::OP_UP2:  t_r  <= t_r - prod_r;
        default: ;
      endcase
    end
  end

  // Event and re-arm decision
  assign first    = restart_r || !have_prev_r;
  assign knz      = (kx_r != '0) || (ky_r != '0);
  assign up_dn    = (AW + 1)'(up_r) + (AW + 1)'(dn_r);
  // interior minimum when 0 <= -up <= dn
  assign interior = !((!up_r[AW-1] && (up_r != '0)) || up_dn[AW]);
  assign le_h2    = OW'(s2_r) <= OW'($signed({1'b0, h2_r}));
  assign gt_r2    = OW'(s2_r) > OW'($signed({1'b0, r2_r}));
  assign s1_le_s2 = s1_r <= s2_r;
  assign t_le_hd  = t_r <= hd_r;
  assign cnt_base = restart_r ? '0 : cnt_r;

  always_comb begin
    fire    = 1'b0;
    armed_n = armed_r;
    if (first) begin
      fire    = le_h2;
      armed_n = !le_h2;
    end else if (knz) begin
      if (!interior) begin
        if (s1_le_s2) begin
          armed_n = armed_r || gt_r2;
        end else begin
          fire    = armed_r && le_h2;
          armed_n = armed_r && !fire;
        end
      end else begin
        fire    = armed_r && t_le_hd;
        armed_n = (armed_r && !fire) || gt_r2;
      end
    end
    if (fire && (cnt_base != CNT_MAX)) begin
      cnt_n = cnt_base + 1'b1;
    end else begin
      cnt_n = cnt_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      armed_r     <= 1'b1;
      cnt_r       <= '0;
      prev_rx_r   <= '0;
      prev_ry_r   <= '0;
    end else if (cmd.decide) begin
      have_prev_r <= 1'b1;
      armed_r     <= armed_n;
      cnt_r       <= cnt_n;
      prev_rx_r   <= rx_r;
      prev_ry_r   <= ry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      ev_r <= fire;
    end
  end

  // Tracker state only moves at a decision, so it doubles as the result.
  assign out_event_now   = ev_r;
  assign out_event_total = phc_pkg::TOTAL_BITS'(cnt_r);
  assign out_is_armed    = armed_r;

endmodule

[design/proximity_hysteresis_counter.sv]
// Top level of the proximity hysteresis counter.
// Each request carries one position sample of two objects; the block finds the
// closest approach on the straight segment from the previous sample (endpoint or
// interior minimum, tested exactly in integers) and counts an event when an armed
// tracker comes within hello_radius, re-arming once a sample lies beyond
// reset_radius. A request is taken only while the block is idle: a single shared
// signed multiplier forms the 13 products the test needs (squared radii, |r|^2 of
// both samples, |k|^2, r.k and the three wide cross terms), one per cycle,
// followed by a writeback step and a decision step. The result sits in an output
// register, so the next request is taken while it waits; a held result only
// delays the decision of the following request. Configuration writes must be made
// only while the block is idle; the block itself does not enforce this.
module proximity_hysteresis_counter #(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [phc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [phc_pkg::CFG_BITS-1:0]       cfg_wdata,
  // sample requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_first_x,
  input  logic signed [COORD_BITS-1:0]       in_first_y,
  input  logic signed [COORD_BITS-1:0]       in_second_x,
  input  logic signed [COORD_BITS-1:0]       in_second_y,
  input  logic                               in_restart,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_event_now,
  output logic [phc_pkg::TOTAL_BITS-1:0]     out_event_total,
  output logic                               out_is_armed
);

  phc_pkg::phc_cmd_t cmd;

  // sequencing and handshakes
  phc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic, configuration and tracker state
  phc_dp #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_first_x      (in_first_x),
    .in_first_y      (in_first_y),
    .in_second_x     (in_second_x),
    .in_second_y     (in_second_y),
    .in_restart      (in_restart),
    .out_event_now   (out_event_now),
    .out_event_total (out_event_total),
    .out_is_armed    (out_is_armed)
  );

endmodule
